// ----- sv/scde_pkg.sv -----
package scde_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int OP_W      = 4;
    localparam int KEY_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [OP_W-1:0] OP_SORTED_INS   = 4'd0;
    localparam logic [OP_W-1:0] OP_DELETE_KEY   = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT_LAST  = 4'd2;
    localparam logic [OP_W-1:0] OP_DELETE_LAST  = 4'd3;
    localparam logic [OP_W-1:0] OP_INSERT_FIRST = 4'd4;
    localparam logic [OP_W-1:0] OP_DELETE_FIRST = 4'd5;
    localparam logic [OP_W-1:0] OP_INVERT       = 4'd6;
    localparam logic [OP_W-1:0] OP_CLEAR        = 4'd7;
    localparam logic [OP_W-1:0] OP_DUMP         = 4'd8;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_RESP,
        S_DUMP
    } state_t;

endpackage

// ----- sv/scde_ram.sv -----
module scde_ram
    import scde_pkg::*;
#(
    parameter int WIDTH = KEY_W,
    parameter int DEPTH = DEF_CAPACITY,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/sorted_circular_deque_engine_unit.sv -----
// end inserts and deletes, invert, clear and unused codes pass through S_RESP to the output
// register; sorted insert and delete by key first scan the held entries in S_SCAN and then,
// where needed, move entries one at a time in S_SHIFT_UP and S_PLACE or in S_SHIFT_DN
// a dump gives one result per cycle while the output is free to take it; all rates are set by
// the single read port of the key memory, one item is worked on at a time
// reset empties the list (count, front slot and direction); key memory is not cleared
module sorted_circular_deque_engine_unit
    import scde_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // key[31:0]
    input  logic [3:0]  s_axis_tuser,  // op[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // entry_count[6:0], item_key[38:7], zero[39]
    output logic [2:0]  m_axis_tuser,  // status[1:0], item_valid[2]
    output logic        m_axis_tlast
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SW    = CNT_W + 1;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_M1  = CNT_W'(CAPACITY - 1);
    localparam logic [SW-1:0]    CAP_S   = SW'(CAPACITY);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic rev,
                                              input logic [CNT_W-1:0] pos);
        logic [SW-1:0] s;
        if (rev) begin
            s = SW'(f) + CAP_S - SW'(pos);
        end else begin
            s = SW'(f) + SW'(pos);
        end
        if (s >= CAP_S) begin
            s = s - CAP_S;
        end
        return s[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     front_reg, front_next;
    logic              rev_reg, rev_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic [KEY_W-1:0]  m_key_reg;
    logic              m_item_valid_reg;
    logic              m_last_reg;

    logic              rd_en, wr_en;
    logic [CNT_W-1:0]  rd_pos, wr_pos, fr_pos;
    logic [AW-1:0]     rd_slot, wr_slot, fr_slot;
    logic [KEY_W-1:0]  wr_data, rd_data;

    logic              out_free, out_load, out_item_valid, out_last;
    logic [STAT_W-1:0] out_status;
    logic [KEY_W-1:0]  out_key;
    logic              full, empty, at_end, hit;
    logic [CNT_W-1:0]  last_idx;
    logic [CNT_W+CNT_OUT_W-1:0] count_ext;

    assign rd_slot = slot_of(front_reg, rev_reg, rd_pos);
    assign wr_slot = slot_of(front_reg, rev_reg, wr_pos);
    assign fr_slot = slot_of(front_reg, rev_reg, fr_pos);

    scde_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_slot),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_slot),
        .rd_data (rd_data)
    );

    assign full     = (count_reg == CAP_CNT);
    assign empty    = (count_reg == '0);
    assign last_idx = count_reg - CNT_ONE;
    assign at_end   = (i_reg == last_idx);
    assign hit      = (op_reg == OP_SORTED_INS) ? ($signed(rd_data) >= key_reg)
                                                : (rd_data == key_reg);
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            front_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            front_reg   <= front_next;
            rev_reg     <= rev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        pos_reg  <= pos_next;
        op_reg   <= op_next;
        key_reg  <= key_next;
        stat_reg <= stat_next;
        if (out_load) begin
            m_status_reg     <= out_status;
            m_count_reg      <= count_next;
            m_key_reg        <= out_key;
            m_item_valid_reg <= out_item_valid;
            m_last_reg       <= out_last;
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        rev_next       = rev_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        stat_next      = stat_reg;
        rd_en          = 1'b0;
        rd_pos         = '0;
        wr_en          = 1'b0;
        wr_pos         = '0;
        wr_data        = key_reg;
        fr_pos         = '0;
        out_load       = 1'b0;
        out_status     = stat_reg;
        out_key        = '0;
        out_item_valid = 1'b0;
        out_last       = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next    = s_axis_tuser;
                    key_next   = s_axis_tdata;
                    wr_data    = s_axis_tdata;
                    stat_next  = STAT_OK;
                    state_next = S_RESP;
                    unique case (s_axis_tuser)
                        OP_SORTED_INS: begin
                            if (full) begin
                                stat_next = STAT_FULL;
                            end else if (empty) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_ONE;
                            end else begin
                                rd_en      = 1'b1;
                                i_next     = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_DELETE_KEY: begin
                            if (empty) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                i_next     = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_INSERT_LAST: begin
                            if (full) begin
                                stat_next = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_pos     = count_reg;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        OP_DELETE_LAST: begin
                            if (empty) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                count_next = last_idx;
                            end
                        end
                        OP_INSERT_FIRST: begin
                            if (full) begin
                                stat_next = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_ONE;
                                if (!empty) begin
                                    wr_pos     = CAP_M1;
                                    fr_pos     = CAP_M1;
                                    front_next = fr_slot;
                                end
                            end
                        end
                        OP_DELETE_FIRST: begin
                            if (empty) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                fr_pos     = CNT_ONE;
                                front_next = fr_slot;
                                count_next = last_idx;
                            end
                        end
                        OP_INVERT: begin
                            if (empty) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                fr_pos     = last_idx;
                                front_next = fr_slot;
                                rev_next   = !rev_reg;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            front_next = '0;
                            rev_next   = 1'b0;
                        end
                        OP_DUMP: begin
                            if (!empty) begin
                                rd_en      = 1'b1;
                                i_next     = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit || at_end) begin
                    state_next = S_RESP;
                    if (op_reg == OP_SORTED_INS) begin
                        if (hit && (i_reg == '0)) begin
                            wr_en      = 1'b1;
                            wr_pos     = CAP_M1;
                            fr_pos     = CAP_M1;
                            front_next = fr_slot;
                            count_next = count_reg + CNT_ONE;
                        end else if (!hit) begin
                            wr_en      = 1'b1;
                            wr_pos     = count_reg;
                            count_next = count_reg + CNT_ONE;
                        end else begin
                            pos_next   = i_reg;
                            rd_en      = 1'b1;
                            rd_pos     = last_idx;
                            i_next     = last_idx;
                            state_next = S_SHIFT_UP;
                        end
                    end else begin
                        if (!hit) begin
                            stat_next = STAT_MISSING;
                        end else if (i_reg == '0) begin
                            fr_pos     = CNT_ONE;
                            front_next = fr_slot;
                            count_next = last_idx;
                        end else if (at_end) begin
                            count_next = last_idx;
                        end else begin
                            rd_en      = 1'b1;
                            rd_pos     = i_reg + CNT_ONE;
                            i_next     = i_reg + CNT_ONE;
                            state_next = S_SHIFT_DN;
                        end
                    end
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = i_reg + CNT_ONE;
                    i_next = i_reg + CNT_ONE;
                end
            end
            S_SHIFT_UP: begin
                wr_en   = 1'b1;
                wr_pos  = i_reg + CNT_ONE;
                wr_data = rd_data;
                if (i_reg == pos_reg) begin
                    state_next = S_PLACE;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = i_reg - CNT_ONE;
                    i_next = i_reg - CNT_ONE;
                end
            end
            S_PLACE: begin
                wr_en      = 1'b1;
                wr_pos     = pos_reg;
                count_next = count_reg + CNT_ONE;
                state_next = S_RESP;
            end
            S_SHIFT_DN: begin
                wr_en   = 1'b1;
                wr_pos  = i_reg - CNT_ONE;
                wr_data = rd_data;
                if (at_end) begin
                    count_next = last_idx;
                    state_next = S_RESP;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = i_reg + CNT_ONE;
                    i_next = i_reg + CNT_ONE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_status     = STAT_OK;
                    out_key        = rd_data;
                    out_item_valid = 1'b1;
                    out_last       = at_end;
                    if (at_end) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en  = 1'b1;
                        rd_pos = i_reg + CNT_ONE;
                        i_next = i_reg + CNT_ONE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign count_ext     = {{CNT_OUT_W{1'b0}}, m_count_reg};
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_key_reg, count_ext[CNT_OUT_W-1:0]};
    assign m_axis_tuser  = {m_item_valid_reg, m_status_reg};
    assign m_axis_tlast  = m_last_reg;

    // never more keys than slots
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // shifting reads and writes never touch the same slot in one cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_slot != rd_slot))
        else $error("read and write collide on one slot");

    // a clear transfer empties the list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear left keys behind");

    // results without a dumped key carry a zero key
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[38:7] == '0))
        else $error("nonzero key on a plain result");

    // a dump result before the last keeps the engine in the dump
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP && out_load && !out_last) |=> (state_reg == S_DUMP))
        else $error("dump left early");

endmodule

// ----- sim/sorted_circular_deque_engine_unit_tb.sv -----
`timescale 1ns / 100ps

module sorted_circular_deque_engine_unit_tb;
    import scde_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 230;
    localparam int TAIL_CYCLES = 2 * CAP + 12;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        logic [KEY_W-1:0]     key;
        logic                 key_vld;
        logic                 last;
    } deque_resp_t;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [KEY_W-1:0]     key;
        logic                 fixed_exp;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
    } op_row_t;

    localparam int N_ROWS = 25;
    localparam op_row_t OP_ROWS [N_ROWS] = '{
        '{OP_DUMP,         32'h0000_0000, 1'b1, STAT_OK,      7'd0},
        '{OP_DELETE_KEY,   32'h0000_0000, 1'b1, STAT_EMPTY,   7'd0},
        '{OP_DELETE_LAST,  32'h0000_0000, 1'b1, STAT_EMPTY,   7'd0},
        '{OP_DELETE_FIRST, 32'h0000_0000, 1'b1, STAT_EMPTY,   7'd0},
        '{OP_INVERT,       32'h0000_0000, 1'b1, STAT_EMPTY,   7'd0},
        '{OP_SORTED_INS,   32'h7fff_ffff, 1'b1, STAT_OK,      7'd1},
        '{OP_INVERT,       32'h0000_0000, 1'b1, STAT_OK,      7'd1},
        '{OP_DUMP,         32'hffff_ffff, 1'b0, STAT_OK,      7'd0},
        '{OP_SORTED_INS,   32'h8000_0000, 1'b1, STAT_OK,      7'd2},
        '{OP_INSERT_LAST,  32'h0000_0000, 1'b1, STAT_OK,      7'd3},
        '{OP_INSERT_FIRST, 32'hffff_ffff, 1'b1, STAT_OK,      7'd4},
        '{OP_SORTED_INS,   32'h0000_0005, 1'b1, STAT_OK,      7'd5},
        '{OP_DELETE_KEY,   32'h0000_3039, 1'b1, STAT_MISSING, 7'd5},
        '{OP_DUMP,         32'h0000_0000, 1'b0, STAT_OK,      7'd0},
        '{OP_INVERT,       32'h0000_0000, 1'b1, STAT_OK,      7'd5},
        '{OP_SORTED_INS,   32'h0000_0003, 1'b1, STAT_OK,      7'd6},
        '{OP_DUMP,         32'h0000_0000, 1'b0, STAT_OK,      7'd0},
        '{OP_DELETE_KEY,   32'h7fff_ffff, 1'b1, STAT_OK,      7'd5},
        '{OP_DELETE_LAST,  32'h0000_0000, 1'b1, STAT_OK,      7'd4},
        '{OP_DELETE_FIRST, 32'h0000_0000, 1'b1, STAT_OK,      7'd3},
        '{OP_UNUSED_LO,    32'h5555_aaaa, 1'b1, STAT_OK,      7'd3},
        '{OP_UNUSED_HI,    32'haaaa_5555, 1'b1, STAT_OK,      7'd3},
        '{OP_DUMP,         32'h0000_0000, 1'b0, STAT_OK,      7'd0},
        '{OP_CLEAR,        32'h0000_0000, 1'b1, STAT_OK,      7'd0},
        '{OP_DUMP,         32'h0000_0000, 1'b1, STAT_OK,      7'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // key[31:0]
    logic [3:0]  s_axis_tuser = '0;  // op[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // entry_count[6:0], item_key[38:7], zero[39]
    logic [2:0]  m_axis_tuser;       // status[1:0], item_valid[2]
    logic        m_axis_tlast;

    logic signed [KEY_W-1:0] list_keys[$];
    deque_resp_t             deque_responses[$];
    int                      error_cnt = 0;
    int                      cycle_cnt = 0;
    bit                      steady_flow = 1'b0;

    sorted_circular_deque_engine_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_resp(input logic [STAT_W-1:0] st, input logic signed [KEY_W-1:0] k,
                             input logic vld, input logic lst);
        deque_resp_t r;
        r.status  = st;
        r.count   = CNT_OUT_W'(list_keys.size());
        r.key     = k;
        r.key_vld = vld;
        r.last    = lst;
        deque_responses.push_back(r);
    endtask

    task automatic apply_deque_op(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
        int                      pos;
        int                      n;
        logic signed [KEY_W-1:0] flipped[$];
        logic [STAT_W-1:0]       st;
        st = STAT_OK;
        n = list_keys.size();
        case (op)
            OP_SORTED_INS, OP_INSERT_LAST, OP_INSERT_FIRST: begin
                if (n >= CAP) begin
                    st = STAT_FULL;
                end else if (op == OP_INSERT_LAST) begin
                    list_keys.push_back(key);
                end else if (op == OP_INSERT_FIRST) begin
                    list_keys.push_front(key);
                end else begin
                    pos = 0;
                    while (pos < n && list_keys[pos] < key) pos++;
                    list_keys.insert(pos, key);
                end
            end
            OP_DELETE_KEY: begin
                if (n == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < n && list_keys[pos] != key) pos++;
                    if (pos < n) list_keys.delete(pos);
                    else st = STAT_MISSING;
                end
            end
            OP_DELETE_LAST, OP_DELETE_FIRST: begin
                if (n == 0) st = STAT_EMPTY;
                else if (op == OP_DELETE_LAST) void'(list_keys.pop_back());
                else void'(list_keys.pop_front());
            end
            OP_INVERT: begin
                if (n == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    foreach (list_keys[i]) flipped.push_front(list_keys[i]);
                    list_keys = flipped;
                end
            end
            OP_CLEAR: list_keys.delete();
            OP_DUMP: begin
                if (n > 0) begin
                    for (int i = 0; i < n; i++) push_resp(STAT_OK, list_keys[i], 1'b1, i == n - 1);
                    return;
                end
            end
            default: ;
        endcase
        push_resp(st, '0, 1'b0, 1'b1);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic fixed_exp = 1'b0,
                             input logic [STAT_W-1:0] st = STAT_OK,
                             input logic [CNT_OUT_W-1:0] cnt = '0);
        int          n0;
        deque_resp_t r;
        if (!steady_flow) begin
            while ($urandom_range(99) < 32) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        n0 = deque_responses.size();
        apply_deque_op(op, key);
        if (fixed_exp) begin
            while (deque_responses.size() > n0) void'(deque_responses.pop_back());
            r = '{status: st, count: cnt, key: '0, key_vld: 1'b0, last: 1'b1};
            deque_responses.push_back(r);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (deque_responses.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] draw_key(input int held_bias);
        int r;
        r = $urandom_range(99);
        if (list_keys.size() > 0 && r < held_bias)
            return list_keys[$urandom_range(list_keys.size() - 1)];
        r = $urandom_range(99);
        if (r < 35) return KEY_W'($signed($urandom_range(16)) - 8);
        if (r < 50) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_random_op();
        int r;
        r = $urandom_range(99);
        if (r < 22) send_item(OP_SORTED_INS, draw_key(20));
        else if (r < 30) send_item(OP_INSERT_LAST, draw_key(20));
        else if (r < 38) send_item(OP_INSERT_FIRST, draw_key(20));
        else if (r < 55) send_item(OP_DELETE_KEY, draw_key(70));
        else if (r < 62) send_item(OP_DELETE_LAST, $urandom);
        else if (r < 69) send_item(OP_DELETE_FIRST, $urandom);
        else if (r < 76) send_item(OP_INVERT, $urandom);
        else if (r < 84) send_item(OP_DUMP, $urandom);
        else if (r < 87) send_item(OP_CLEAR, $urandom);
        else if (r < 90) send_item(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom);
        else send_item(OP_SORTED_INS, draw_key(20));
    endtask

    task automatic check_response();
        deque_resp_t want;
        if (deque_responses.size() == 0) begin
            $error("result transfer with nothing pending: tdata %h tuser %h tlast %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            error_cnt++;
            return;
        end
        want = deque_responses.pop_front();
        if (m_axis_tuser[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser[1:0]);
            error_cnt++;
        end
        if (m_axis_tdata[6:0] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, m_axis_tdata[6:0]);
            error_cnt++;
        end
        if (m_axis_tdata[38:7] !== want.key) begin
            $error("item_key: expected %h, got %h", want.key, m_axis_tdata[38:7]);
            error_cnt++;
        end
        if (m_axis_tuser[2] !== want.key_vld) begin
            $error("item_valid: expected %b, got %b", want.key_vld, m_axis_tuser[2]);
            error_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, m_axis_tlast);
            error_cnt++;
        end
        if (m_axis_tdata[39] !== 1'b0) begin
            $error("tdata pad: expected 0, got %b", m_axis_tdata[39]);
            error_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) check_response();
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 32);
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++)
            send_item(OP_ROWS[i].op, OP_ROWS[i].key, OP_ROWS[i].fixed_exp,
                      OP_ROWS[i].status, OP_ROWS[i].count);

        // grow to full, then hit the full and long-scan corners
        repeat (CAP) begin
            case ($urandom_range(2))
                0: send_item(OP_SORTED_INS, draw_key(10));
                1: send_item(OP_INSERT_LAST, draw_key(10));
                default: send_item(OP_INSERT_FIRST, draw_key(10));
            endcase
        end
        send_item(OP_SORTED_INS, 32'h8000_0000, 1'b1, STAT_FULL, 7'd64);
        send_item(OP_INSERT_LAST, 32'h7fff_ffff, 1'b1, STAT_FULL, 7'd64);
        send_item(OP_INSERT_FIRST, 32'h0000_0000, 1'b1, STAT_FULL, 7'd64);
        send_item(OP_DUMP, $urandom);
        send_item(OP_INVERT, $urandom);
        send_item(OP_DELETE_KEY, list_keys[CAP - 1]);
        send_item(OP_SORTED_INS, 32'h7fff_ffff);
        send_item(OP_DELETE_KEY, draw_key(0));
        send_item(OP_DUMP, $urandom);
        wait_drained();
        send_item(OP_CLEAR, $urandom);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 120 && n < 180);
            if (n == 200) wait_drained();
            send_random_op();
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_cnt == 0 && deque_responses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/scde_pkg.sv
sv/scde_ram.sv
sv/sorted_circular_deque_engine_unit.sv
sim/sorted_circular_deque_engine_unit_tb.sv
